/* rtl/core/dmix_pkg.sv */
package dmix_pkg;

  localparam int unsigned CmdW = 16;  // command words, in and out
  localparam int unsigned LimW = 15;  // command limit
  localparam int unsigned SumW = 17;  // throttle +/- steering
  localparam int unsigned MagW = 16;  // magnitude of a sum
  localparam int unsigned QuoW = 15;  // scaled magnitude, never above the limit
  localparam int unsigned RemW = 31;  // magnitude * limit

  localparam logic [LimW-1:0] LimitRst = 15'd1000;

  // Beat handed from cell to cell along the divider row.
  typedef struct packed {
    logic            vld;
    logic            scale;
    logic [MagW-1:0] dvsr;
    logic            neg_l;
    logic            neg_r;
    logic [RemW-1:0] rem_l;
    logic [RemW-1:0] rem_r;
    logic [QuoW-1:0] quo_l;
    logic [QuoW-1:0] quo_r;
  } dmix_div_t;

endpackage

/* rtl/core/differential_drive_mixer.sv */
// Throughput: one beat per cycle; the 15-cell divider row and all front stages are
// fully pipelined, and the whole pipe holds only while a result is stalled at the output.
// Reset: clears all valid bits and sets the command limit to 1000.
module differential_drive_mixer (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [dmix_pkg::LimW-1:0]        cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic signed [dmix_pkg::CmdW-1:0] throttle_i,
  input  logic signed [dmix_pkg::CmdW-1:0] steering_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [dmix_pkg::CmdW-1:0] left_cmd_o,
  output logic signed [dmix_pkg::CmdW-1:0] right_cmd_o
);

  localparam int unsigned CmdW = dmix_pkg::CmdW;
  localparam int unsigned LimW = dmix_pkg::LimW;
  localparam int unsigned QuoW = dmix_pkg::QuoW;

  logic [LimW-1:0]     lim_q;
  logic                en;
  logic                out_vld_q;
  logic [CmdW-1:0]     left_q, left_d, right_q, right_d;
  dmix_pkg::dmix_div_t chain [QuoW+1];
  logic signed [CmdW:0] lim_s;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q <= dmix_pkg::LimitRst;
    end else if (cfg_we_i) begin
      lim_q <= cfg_wdata_i;
    end
  end

  // hold the whole pipe while the output beat is stalled
  assign en         = !(out_vld_q && out_stall_i);
  assign in_stall_o = !en;

  dmix_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .lim_i     (lim_q),
    .vld_i     (in_valid_i),
    .throttle_i(throttle_i),
    .steering_i(steering_i),
    .div_o     (chain[0])
  );

  for (genvar k = 0; k < QuoW; k++) begin : g_cell
    dmix_div_cell #(
      .Bit(QuoW - 1 - k)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (en),
      .cell_i(chain[k]),
      .cell_o(chain[k+1])
    );
  end

  // restore the signs: quotients were taken on magnitudes, truncating toward zero
  always_comb begin
    left_d  = chain[QuoW].neg_l ? CmdW'(0) - {1'b0, chain[QuoW].quo_l}
                                : {1'b0, chain[QuoW].quo_l};
    right_d = chain[QuoW].neg_r ? CmdW'(0) - {1'b0, chain[QuoW].quo_r}
                                : {1'b0, chain[QuoW].quo_r};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= chain[QuoW].vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      left_q  <= left_d;
      right_q <= right_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign left_cmd_o  = left_q;
  assign right_cmd_o = right_q;

  assign lim_s = $signed({2'b00, lim_q});

`ifndef ASSERT_OFF
  a_left_in_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> ($signed({left_cmd_o[CmdW-1], left_cmd_o}) <= lim_s) &&
                  ($signed({left_cmd_o[CmdW-1], left_cmd_o}) >= -lim_s))
    else $error("left command outside limit");
  a_right_in_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> ($signed({right_cmd_o[CmdW-1], right_cmd_o}) <= lim_s) &&
                  ($signed({right_cmd_o[CmdW-1], right_cmd_o}) >= -lim_s))
    else $error("right command outside limit");
`endif

endmodule

/* rtl/core/dmix_front.sv */
module dmix_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic [dmix_pkg::LimW-1:0]     lim_i,
  input  logic                          vld_i,
  input  logic signed [dmix_pkg::CmdW-1:0] throttle_i,
  input  logic signed [dmix_pkg::CmdW-1:0] steering_i,
  output dmix_pkg::dmix_div_t           div_o
);

  localparam int unsigned CmdW = dmix_pkg::CmdW;
  localparam int unsigned SumW = dmix_pkg::SumW;
  localparam int unsigned MagW = dmix_pkg::MagW;
  localparam int unsigned QuoW = dmix_pkg::QuoW;
  localparam int unsigned RemW = dmix_pkg::RemW;

  // stage 1: clamp inputs
  logic                   s1_vld_q;
  logic signed [CmdW-1:0] s1_thr_q, s1_thr_d, s1_str_q, s1_str_d;
  // stage 2: mix
  logic                   s2_vld_q;
  logic signed [SumW-1:0] s2_left_q, s2_left_d, s2_right_q, s2_right_d;
  // stage 3: magnitudes and peak
  logic                   s3_vld_q;
  logic [MagW-1:0]        s3_mag_l_q, s3_mag_l_d, s3_mag_r_q, s3_mag_r_d;
  logic [MagW-1:0]        s3_peak_q, s3_peak_d;
  logic                   s3_neg_l_q, s3_neg_r_q, s3_scale_q, s3_scale_d;
  // stage 4: products
  logic                   s4_vld_q;
  dmix_pkg::dmix_div_t    s4_div_q, s4_div_d;

  logic signed [SumW-1:0] lim_s, neg_lim_s, thr_x, str_x;
  logic signed [SumW-1:0] abs_l, abs_r;

  assign lim_s     = $signed({2'b00, lim_i});
  assign neg_lim_s = -lim_s;
  assign thr_x     = {throttle_i[CmdW-1], throttle_i};
  assign str_x     = {steering_i[CmdW-1], steering_i};

  always_comb begin
    if (thr_x > lim_s) s1_thr_d = lim_s[CmdW-1:0];
    else if (thr_x < neg_lim_s) s1_thr_d = neg_lim_s[CmdW-1:0];
    else s1_thr_d = thr_x[CmdW-1:0];
    if (str_x > lim_s) s1_str_d = lim_s[CmdW-1:0];
    else if (str_x < neg_lim_s) s1_str_d = neg_lim_s[CmdW-1:0];
    else s1_str_d = str_x[CmdW-1:0];
  end

  assign s2_left_d  = {s1_thr_q[CmdW-1], s1_thr_q} + {s1_str_q[CmdW-1], s1_str_q};
  assign s2_right_d = {s1_thr_q[CmdW-1], s1_thr_q} - {s1_str_q[CmdW-1], s1_str_q};

  always_comb begin
    abs_l      = s2_left_q[SumW-1] ? -s2_left_q : s2_left_q;
    abs_r      = s2_right_q[SumW-1] ? -s2_right_q : s2_right_q;
    s3_mag_l_d = abs_l[MagW-1:0];
    s3_mag_r_d = abs_r[MagW-1:0];
    s3_peak_d  = (s3_mag_r_d > s3_mag_l_d) ? s3_mag_r_d : s3_mag_l_d;
    s3_scale_d = s3_peak_d > {1'b0, lim_i};
  end

  always_comb begin
    s4_div_d       = '0;
    s4_div_d.vld   = s3_vld_q;
    s4_div_d.scale = s3_scale_q;
    s4_div_d.dvsr  = s3_peak_q;
    s4_div_d.neg_l = s3_neg_l_q;
    s4_div_d.neg_r = s3_neg_r_q;
    s4_div_d.rem_l = RemW'(s3_mag_l_q * lim_i);
    s4_div_d.rem_r = RemW'(s3_mag_r_q * lim_i);
    // unscaled beats ride through the row with the magnitude already in place
    s4_div_d.quo_l = s3_scale_q ? '0 : s3_mag_l_q[QuoW-1:0];
    s4_div_d.quo_r = s3_scale_q ? '0 : s3_mag_r_q[QuoW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
    end else if (en_i) begin
      s1_vld_q <= vld_i;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_thr_q   <= s1_thr_d;
      s1_str_q   <= s1_str_d;
      s2_left_q  <= s2_left_d;
      s2_right_q <= s2_right_d;
      s3_mag_l_q <= s3_mag_l_d;
      s3_mag_r_q <= s3_mag_r_d;
      s3_peak_q  <= s3_peak_d;
      s3_neg_l_q <= s2_left_q[SumW-1];
      s3_neg_r_q <= s2_right_q[SumW-1];
      s3_scale_q <= s3_scale_d;
      s4_div_q   <= s4_div_d;
    end
  end

  always_comb begin
    div_o     = s4_div_q;
    div_o.vld = s4_vld_q;
  end

endmodule

/* rtl/core/dmix_div_cell.sv */
module dmix_div_cell #(
  parameter int unsigned Bit = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  dmix_pkg::dmix_div_t cell_i,
  output dmix_pkg::dmix_div_t cell_o
);

  localparam int unsigned RemW = dmix_pkg::RemW;

  logic [RemW-1:0]     sub_in, sub_out;
  logic [RemW:0]       trial_l, trial_r;
  logic                vld_q;
  dmix_pkg::dmix_div_t data_q, data_d;

  assign sub_in  = RemW'(cell_i.dvsr) << Bit;
  assign trial_l = {1'b0, cell_i.rem_l} - {1'b0, sub_in};
  assign trial_r = {1'b0, cell_i.rem_r} - {1'b0, sub_in};

  // on scaled beats, one restoring step per lane: keep the difference when it does not borrow
  always_comb begin
    data_d = cell_i;
    if (cell_i.scale && !trial_l[RemW]) begin
      data_d.rem_l      = trial_l[RemW-1:0];
      data_d.quo_l[Bit] = 1'b1;
    end
    if (cell_i.scale && !trial_r[RemW]) begin
      data_d.rem_r      = trial_r[RemW-1:0];
      data_d.quo_r[Bit] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= cell_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  always_comb begin
    cell_o     = data_q;
    cell_o.vld = vld_q;
  end

  assign sub_out = RemW'(cell_o.dvsr) << Bit;

`ifndef ASSERT_OFF
  a_rem_l_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_o.vld && cell_o.scale |-> cell_o.rem_l < sub_out)
    else $error("left remainder not below shifted divisor");
  a_rem_r_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_o.vld && cell_o.scale |-> cell_o.rem_r < sub_out)
    else $error("right remainder not below shifted divisor");
`endif

endmodule
